### src/pdri_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdri_pkg
// Shared constants, angle table and handshake structs for the planar
// dead-reckoning integrator.
// ----------------------------------------------------------------------------
package pdri_pkg;

  // cordic
  localparam int CORDIC_STEPS   = 16;
  localparam int ANGLE_TABLE_LEN = 24;
  localparam int STEP_W         = $clog2(ANGLE_TABLE_LEN);
  localparam int XY_W           = 34;
  localparam int ANG_W          = 33;
  localparam logic signed [XY_W-1:0] INV_GAIN_Q30 = XY_W'(652032874);

  // heading change scale, 2^-32 turn per (1/4096 rad/s * 1 us)
  localparam logic signed [XY_W-1:0] DTH_SCALE = XY_W'(716770142);

  // distance divider
  localparam int DIST_DIVISOR = 62500;
  localparam int QUO_W        = 17;
  localparam int DVD_W        = 33;
  // the divisor is 4 * 15625: the dividend over 4 (31 bits) times
  // ceil(2^45 / 15625), shifted down by 45, is the exact floor quotient
  localparam int NUM_W        = DVD_W - 2;
  localparam int PROD_W       = 48;
  localparam int DIST_SHIFT   = 45;
  localparam logic [31:0] DIST_RECIP = 32'd2251799814;
  // half divisor for rounding plus an offset of 65536 divisors that keeps
  // the dividend positive
  localparam logic [DVD_W:0] DIV_BIAS = (DVD_W+1)'(64'd31250 + 64'd62500 * 64'd65536);
  localparam logic signed [17:0] QUO_OFFSET = 18'sd65536;

  // multiplier operand widths
  localparam int MA_W = 18;
  localparam int MP_W = MA_W + XY_W;

  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic                   busy;
    logic signed [XY_W-1:0] cos_v;
    logic signed [XY_W-1:0] sin_v;
  } cordic_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [ANG_W-1:0] angle_step(input logic [STEP_W-1:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return {1'b0, a};
  endfunction

endpackage
`default_nettype wire

### src/pdri_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdri_in_if / pdri_out_if
// Valid/ready channels for odometry ticks and pose results.
// ----------------------------------------------------------------------------
interface pdri_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] linear_velocity;
  logic signed [15:0] yaw_rate;
  logic        [15:0] elapsed_time;

  modport source (output valid, output linear_velocity, output yaw_rate,
                  output elapsed_time, input ready);
  modport sink   (input valid, input linear_velocity, input yaw_rate,
                  input elapsed_time, output ready);
endinterface

interface pdri_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_x;
  logic signed [31:0] position_y;
  logic        [15:0] heading_angle;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  logic signed [15:0] speed_out;
  logic signed [15:0] turn_rate_out;

  modport source (output valid, output position_x, output position_y,
                  output heading_angle, output quat_z, output quat_w,
                  output speed_out, output turn_rate_out, input ready);
  modport sink   (input valid, input position_x, input position_y,
                  input heading_angle, input quat_z, input quat_w,
                  input speed_out, input turn_rate_out, output ready);
endinterface
`default_nettype wire

### src/pdri_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdri_cordic
// Iterative rotation-mode cordic, one micro-rotation per cycle, with
// quadrant folding of a 32-bit binary angle.
// ----------------------------------------------------------------------------
module pdri_cordic (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pdri_pkg::cordic_req_t req,
  output pdri_pkg::cordic_rsp_t rsp
);
  import pdri_pkg::*;

  logic signed [XY_W-1:0]  x_r, x_nxt;
  logic signed [XY_W-1:0]  y_r, y_nxt;
  logic signed [ANG_W-1:0] z_r, z_nxt;
  logic [STEP_W-1:0]       i_r, i_nxt;
  logic [1:0]              q_r, q_nxt;
  logic                    busy_r, busy_nxt;

  logic [31:0]             q_sum;
  logic [31:0]             z_start;
  logic signed [XY_W-1:0]  xs, ys;
  logic signed [ANG_W-1:0] ang;

  always_comb begin
    q_sum   = req.angle + 32'h2000_0000;
    z_start = req.angle - {q_sum[31:30], 30'd0};
    xs      = x_r >>> i_r;
    ys      = y_r >>> i_r;
    ang     = angle_step(i_r);

    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    i_nxt    = i_r;
    q_nxt    = q_r;
    busy_nxt = busy_r;

    if (req.start) begin
      x_nxt    = INV_GAIN_Q30;
      y_nxt    = '0;
      z_nxt    = {z_start[31], z_start};
      i_nxt    = '0;
      q_nxt    = q_sum[31:30];
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[ANG_W-1]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - ang;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + ang;
      end
      i_nxt = i_r + 1'b1;
      if (i_r == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
      q_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      i_r    <= i_nxt;
      q_r    <= q_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  // rotate back by the quadrant
  always_comb begin
    rsp.busy = busy_r;
    case (q_r)
      2'd0: begin
        rsp.cos_v = x_r;
        rsp.sin_v = y_r;
      end
      2'd1: begin
        rsp.cos_v = -y_r;
        rsp.sin_v = x_r;
      end
      2'd2: begin
        rsp.cos_v = -x_r;
        rsp.sin_v = -y_r;
      end
      default: begin
        rsp.cos_v = y_r;
        rsp.sin_v = -x_r;
      end
    endcase
  end

endmodule
`default_nettype wire

### src/pdri_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdri_div
// Divider by the fixed distance divisor: a reciprocal multiply split into
// two halves, low then high, on one 16x32 multiplier.
// ----------------------------------------------------------------------------
module pdri_div (
  input  logic               clk,
  input  logic               rst_n,
  input  pdri_pkg::div_req_t req,
  output pdri_pkg::div_rsp_t rsp
);
  import pdri_pkg::*;

  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [PROD_W-1:0] lo_r, lo_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic              hi_r, hi_nxt;
  logic              busy_r, busy_nxt;

  logic [15:0]       part;
  logic [PROD_W-1:0] prod;
  logic [63:0]       sum;

  always_comb begin
    // low half first, then the high half weighted by 2^16
    part = hi_r ? {1'b0, num_r[NUM_W-1:16]} : num_r[15:0];
    prod = part * DIST_RECIP;
    sum  = {prod, 16'd0} + {16'd0, lo_r};

    num_nxt  = num_r;
    lo_nxt   = lo_r;
    quo_nxt  = quo_r;
    hi_nxt   = hi_r;
    busy_nxt = busy_r;

    if (req.start) begin
      // the divisor's factor of 4 comes off as a shift
      num_nxt  = req.dividend[DVD_W-1:2];
      hi_nxt   = 1'b0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!hi_r) begin
        lo_nxt = prod;
        hi_nxt = 1'b1;
      end else begin
        quo_nxt  = sum[DIST_SHIFT+QUO_W-1:DIST_SHIFT];
        hi_nxt   = 1'b0;
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      hi_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      hi_r   <= hi_nxt;
    end
    num_r <= num_nxt;
    lo_r  <= lo_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

### src/planar_dead_reckoning_integrator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// planar_dead_reckoning_integrator_unit
// Dead-reckoning pose integrator: distance and heading change per tick, an
// x/y step along the old heading, wrapping binary-angle heading, quaternion.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  in_ch    in   linear_velocity, yaw_rate, elapsed_time
//  out_ch   out  position_x/y, heading_angle, quat_z/w, speed_out, turn_rate_out
//
//  the two 16-step cordic passes set the pace of a tick from acceptance to its
//  result beat when the output register is free: the first (old heading) runs
//  beside the shared 18x34 multiplies and the reciprocal-multiply distance
//  divide, the second (new half heading) feeds the quaternion. synchronous
//  active-low reset clears pose and heading.
//  in_ch is ready only between ticks; a result waiting in the output register
//  stalls the end of the following tick, not its acceptance.
// ----------------------------------------------------------------------------
module planar_dead_reckoning_integrator_unit (
  input  logic              clk,
  input  logic              rst_n,
  pdri_in_if.sink           in_ch,
  pdri_out_if.source        out_ch
);
  import pdri_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_MVD  = 12'b0000_0000_0010,
    ST_MWD  = 12'b0000_0000_0100,
    ST_MLO  = 12'b0000_0000_1000,
    ST_MHI  = 12'b0000_0001_0000,
    ST_ACC  = 12'b0000_0010_0000,
    ST_WDIV = 12'b0000_0100_0000,
    ST_MX   = 12'b0000_1000_0000,
    ST_MY   = 12'b0001_0000_0000,
    ST_UY   = 12'b0010_0000_0000,
    ST_WQ   = 12'b0100_0000_0000,
    ST_FIN  = 12'b1000_0000_0000
  } state_t;

  state_t             state_r, state_nxt;

  logic signed [15:0] v_r, w_r;
  logic [15:0]        dt_r;
  logic [32:0]        wd_r;
  logic signed [63:0] acc_r;
  logic [31:0]        dth_r;
  logic [31:0]        pose_x_r, pose_x_nxt;
  logic [31:0]        pose_y_r, pose_y_nxt;
  logic [31:0]        hdg_r, hdg_nxt;
  logic signed [MP_W-1:0] mul_r;
  logic signed [MA_W-1:0] mul_a;
  logic signed [XY_W-1:0] mul_b;

  logic               out_valid_r;
  logic [31:0]        ox_r, oy_r;
  logic [15:0]        ohdg_r, oqz_r, oqw_r, ospd_r, oturn_r;

  cordic_req_t        cor_req;
  cordic_rsp_t        cor_rsp;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic signed [17:0] step_len;
  logic [XY_W-1:0]    div_sum;
  logic signed [63:0] dth_sum;
  logic signed [MP_W-1:0] step_rnd;
  logic [21:0]        step_d;
  logic [33:0]        pos_sum;
  logic               out_free;

  pdri_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cor_req),
    .rsp   (cor_rsp)
  );

  pdri_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  function automatic logic [31:0] sat32(input logic [33:0] s);
    if (!s[33] && (s[32:31] != 2'b00)) begin
      return 32'h7FFF_FFFF;
    end else if (s[33] && (s[32:31] != 2'b11)) begin
      return 32'h8000_0000;
    end else begin
      return s[31:0];
    end
  endfunction

  // round Q30 to Q14 and clamp to +-1.0
  function automatic logic [15:0] to_q14(input logic signed [XY_W-1:0] c);
    logic signed [XY_W-1:0] r;
    r = (c + XY_W'(32768)) >>> 16;
    if (r > XY_W'(16384)) begin
      return 16'sd16384;
    end else if (r < -XY_W'(16384)) begin
      return -16'sd16384;
    end else begin
      return r[15:0];
    end
  endfunction

  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign step_len    = $signed({1'b0, div_rsp.quotient}) - QUO_OFFSET;
  assign div_sum     = {mul_r[32], mul_r[32:0]} + DIV_BIAS;
  assign dth_sum     = acc_r + ({{(64-MP_W){mul_r[MP_W-1]}}, mul_r} <<< 16);
  assign step_rnd    = (mul_r + MP_W'(64'sd536870912)) >>> 30;
  assign step_d      = step_rnd[21:0];
  assign hdg_nxt     = hdg_r + dth_r;

  assign div_req.start    = (state_r == ST_MWD);
  assign div_req.dividend = div_sum[DVD_W-1:0];
  assign cor_req.start    = (state_r == ST_MVD) || (state_r == ST_UY);
  assign cor_req.angle    = (state_r == ST_UY) ? {1'b0, hdg_nxt[31:1]} : hdg_r;

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MVD: begin
        mul_a = {{2{v_r[15]}}, v_r};
        mul_b = {{(XY_W-16){1'b0}}, dt_r};
      end
      ST_MWD: begin
        mul_a = {{2{w_r[15]}}, w_r};
        mul_b = {{(XY_W-16){1'b0}}, dt_r};
      end
      ST_MLO: begin
        mul_a = {2'b00, mul_r[15:0]};
        mul_b = DTH_SCALE;
      end
      ST_MHI: begin
        mul_a = {wd_r[32], wd_r[32:16]};
        mul_b = DTH_SCALE;
      end
      ST_MX: begin
        mul_a = step_len;
        mul_b = cor_rsp.cos_v;
      end
      ST_MY: begin
        mul_a = step_len;
        mul_b = cor_rsp.sin_v;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    pos_sum    = {{2{pose_x_r[31]}}, pose_x_r} + {{12{step_d[21]}}, step_d};
    pose_x_nxt = pose_x_r;
    pose_y_nxt = pose_y_r;
    if (state_r == ST_MY) begin
      pose_x_nxt = sat32(pos_sum);
    end
    if (state_r == ST_UY) begin
      pos_sum    = {{2{pose_y_r[31]}}, pose_y_r} + {{12{step_d[21]}}, step_d};
      pose_y_nxt = sat32(pos_sum);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_MVD;
      ST_MVD:  state_nxt = ST_MWD;
      ST_MWD:  state_nxt = ST_MLO;
      ST_MLO:  state_nxt = ST_MHI;
      ST_MHI:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_WDIV;
      ST_WDIV: if (!div_rsp.busy && !cor_rsp.busy) state_nxt = ST_MX;
      ST_MX:   state_nxt = ST_MY;
      ST_MY:   state_nxt = ST_UY;
      ST_UY:   state_nxt = ST_WQ;
      ST_WQ:   if (!cor_rsp.busy) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      hdg_r       <= '0;
    end else begin
      state_r  <= state_nxt;
      pose_x_r <= pose_x_nxt;
      pose_y_r <= pose_y_nxt;
      if (state_r == ST_UY) begin
        hdg_r <= hdg_nxt;
      end
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    if (in_ch.valid && in_ch.ready) begin
      v_r  <= in_ch.linear_velocity;
      w_r  <= in_ch.yaw_rate;
      dt_r <= in_ch.elapsed_time;
    end
    if (state_r == ST_MLO) begin
      wd_r <= mul_r[32:0];
    end
    if (state_r == ST_MHI) begin
      acc_r <= {{(64-MP_W){mul_r[MP_W-1]}}, mul_r} + 64'sd2147483648;
    end
    if (state_r == ST_ACC) begin
      dth_r <= dth_sum[63:32];
    end
    if ((state_r == ST_FIN) && out_free) begin
      ox_r    <= pose_x_r;
      oy_r    <= pose_y_r;
      ohdg_r  <= hdg_r[31:16];
      oqz_r   <= to_q14(cor_rsp.sin_v);
      oqw_r   <= to_q14(cor_rsp.cos_v);
      ospd_r  <= (dt_r != 16'd0) ? v_r : 16'sd0;
      oturn_r <= (dt_r != 16'd0) ? w_r : 16'sd0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.position_x    = ox_r;
  assign out_ch.position_y    = oy_r;
  assign out_ch.heading_angle = ohdg_r;
  assign out_ch.quat_z        = oqz_r;
  assign out_ch.quat_w        = oqw_r;
  assign out_ch.speed_out     = ospd_r;
  assign out_ch.turn_rate_out = oturn_r;

endmodule
`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the planar dead-reckoning integrator. An in-bench
// fixed-point pose integrator (own cordic) predicts every pose beat. It is fed
// by directed ticks, random ticks under several idle/stall mixes, a long
// receiver hold, and a flat-out run along a diagonal heading.
// ----------------------------------------------------------------------------
module tb_top;

  localparam longint CYCLE_LIMIT   = 500_000;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     SETTLE_CYCLES = 100;
  localparam int     MAX_REPORTS   = 10;
  localparam int     PHASE_TICKS   = 210;
  localparam int     ROT_STEPS     = 16;
  localparam longint START_X_Q30   = 652032874;
  localparam longint TURN_PER_UNIT = 716770142;
  localparam longint DIST_DIV      = 62500;
  localparam longint POS_MAX       = 64'sd2147483647;
  localparam longint POS_MIN       = -64'sd2147483648;
  localparam longint Q14_ONE       = 16384;
  localparam longint STEER_TOL     = 64'sd1 << 18;
  localparam logic [31:0] DIAG_HEADING = 32'hE000_0000;

  typedef enum logic [1:0] {QUAD_E, QUAD_N, QUAD_W, QUAD_S} quadrant_e;

  typedef struct packed {
    logic signed [15:0] speed;
    logic signed [15:0] turn;
    logic        [15:0] dt_us;
  } tick_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [15:0] hdg;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic signed [15:0] spd;
    logic signed [15:0] trn;
  } pose_t;

  logic clk;
  logic rst_n;

  pdri_in_if  tick_if ();
  pdri_out_if pose_if ();

  planar_dead_reckoning_integrator_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (tick_if),
    .out_ch (pose_if)
  );

  tick_t  tick_q[$];
  pose_t  expected_poses[$];
  tick_t  offered;
  pose_t  seen;
  pose_t  want;
  int     fault_count  = 0;
  longint cycle_count  = 0;
  int     tx_idle_pct  = 0;
  int     rx_stall_pct = 0;
  logic   hold_start   = 1'b0;
  logic   rx_hold      = 1'b0;

  // predicted pose state
  logic signed [31:0] est_x       = '0;
  logic signed [31:0] est_y       = '0;
  logic        [31:0] est_heading = '0;

  function automatic longint round_sh(input longint v, input int s);
    return (v + (64'sd1 << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // atan(2^-i) in 2^-32 turn
  function automatic longint atan_turn(input int i);
    case (i)
      0:       return 64'h20000000;
      1:       return 64'h12E4051E;
      2:       return 64'h09FB385B;
      3:       return 64'h051111D4;
      4:       return 64'h028B0D43;
      5:       return 64'h0145D7E1;
      6:       return 64'h00A2F61E;
      7:       return 64'h00517C55;
      8:       return 64'h0028BE53;
      9:       return 64'h00145F2F;
      10:      return 64'h000A2F98;
      11:      return 64'h000517CC;
      12:      return 64'h00028BE6;
      13:      return 64'h000145F3;
      14:      return 64'h0000A2FA;
      default: return 64'h0000517D;
    endcase
  endfunction

  // cos/sin in Q2.30 of a binary angle
  function automatic void cordic_sincos(input logic [31:0] ang, output longint c,
                                        output longint s);
    logic [31:0] q32;
    quadrant_e   quad;
    longint      x, y, z, xs, ys;
    q32  = (ang + 32'h2000_0000) >> 30;
    quad = quadrant_e'(q32[1:0]);
    // residual around the nearest quadrant axis
    z = $signed(ang - {q32[1:0], 30'd0});
    x = START_X_Q30;
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_turn(i);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + atan_turn(i);
      end
    end
    case (quad)
      QUAD_E:  begin c = x;  s = y;  end
      QUAD_N:  begin c = -y; s = x;  end
      QUAD_W:  begin c = -x; s = -y; end
      default: begin c = y;  s = -x; end
    endcase
  endfunction

  // advance the predicted pose by one tick and queue the expected beat
  function automatic void integrate_tick(input tick_t t);
    longint v, w, dt, num, travel, dth, c, s;
    pose_t  p;
    v   = t.speed;
    w   = t.turn;
    dt  = t.dt_us;
    num = v * dt + DIST_DIV / 2;
    if (num >= 0) begin
      travel = num / DIST_DIV;
    end else begin
      travel = -((-num + DIST_DIV - 1) / DIST_DIV);
    end
    dth = round_sh(w * dt * TURN_PER_UNIT, 32);
    // step along the heading held before this tick
    cordic_sincos(est_heading, c, s);
    est_x       = 32'(clamp(longint'(est_x) + round_sh(travel * c, 30), POS_MIN, POS_MAX));
    est_y       = 32'(clamp(longint'(est_y) + round_sh(travel * s, 30), POS_MIN, POS_MAX));
    est_heading = est_heading + dth[31:0];
    cordic_sincos(est_heading >> 1, c, s);
    p.x   = est_x;
    p.y   = est_y;
    p.hdg = est_heading[31:16];
    p.qw  = 16'(clamp(round_sh(c, 16), -Q14_ONE, Q14_ONE));
    p.qz  = 16'(clamp(round_sh(s, 16), -Q14_ONE, Q14_ONE));
    p.spd = (dt != 0) ? t.speed : 16'sd0;
    p.trn = (dt != 0) ? t.turn  : 16'sd0;
    expected_poses.push_back(p);
  endfunction

  function automatic logic signed [15:0] rand_rate();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return 16'($urandom);
    if (pick < 8) return 16'($urandom_range(0, 400) - 200);
    return (pick == 8) ? 16'sh7FFF : 16'sh8000;
  endfunction

  function automatic logic [15:0] rand_dt();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 16'd0;
    if (pick < 4)  return 16'($urandom_range(1, 100));
    if (pick == 4) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic push_tick(input logic signed [15:0] v, input logic signed [15:0] w,
                           input logic [15:0] dt);
    tick_t t;
    t.speed = v;
    t.turn  = w;
    t.dt_us = dt;
    tick_q.push_back(t);
  endtask

  // sender pause: wait until every queued tick is in and every pose is out;
  // sampled at the falling edge so the rising-edge updates have settled
  task automatic wait_idle();
    @(negedge clk);
    while (tick_q.size() != 0 || tick_if.valid || expected_poses.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n                   = 1'b0;
    tick_if.valid           = 1'b0;
    tick_if.linear_velocity = '0;
    tick_if.yaw_rate        = '0;
    tick_if.elapsed_time    = '0;
    pose_if.ready           = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      tick_if.valid <= 1'b0;
    end else begin
      if (tick_if.valid && tick_if.ready) begin
        integrate_tick(offered);
      end
      if (!tick_if.valid || tick_if.ready) begin
        if (tick_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          offered = tick_q.pop_front();
          tick_if.valid           <= 1'b1;
          tick_if.linear_velocity <= offered.speed;
          tick_if.yaw_rate        <= offered.turn;
          tick_if.elapsed_time    <= offered.dt_us;
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      pose_if.ready <= 1'b0;
    end else begin
      if (pose_if.valid && pose_if.ready) begin
        seen.x   = pose_if.position_x;
        seen.y   = pose_if.position_y;
        seen.hdg = pose_if.heading_angle;
        seen.qz  = pose_if.quat_z;
        seen.qw  = pose_if.quat_w;
        seen.spd = pose_if.speed_out;
        seen.trn = pose_if.turn_rate_out;
        if (expected_poses.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("unexpected pose beat: x %0d y %0d hdg %0d", seen.x, seen.y,
                     seen.hdg);
        end else begin
          want = expected_poses.pop_front();
          if (seen.x !== want.x || seen.y !== want.y || seen.hdg !== want.hdg ||
              seen.qz !== want.qz || seen.qw !== want.qw || seen.spd !== want.spd ||
              seen.trn !== want.trn) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS) begin
              $display("pose mismatch exp: x %0d y %0d hdg %0d qz %0d qw %0d spd %0d trn %0d",
                       want.x, want.y, want.hdg, want.qz, want.qw, want.spd, want.trn);
              $display("pose mismatch got: x %0d y %0d hdg %0d qz %0d qw %0d spd %0d trn %0d",
                       seen.x, seen.y, seen.hdg, seen.qz, seen.qw, seen.spd, seen.trn);
            end
          end
        end
      end
      pose_if.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // long receiver hold so the block backs up into its input
  initial begin
    while (!hold_start) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    longint err;
    longint turn_units;
    while (!rst_n) @(posedge clk);

    push_tick(16'sd0, 16'sd0, 16'd0);
    // zero elapsed time hides speed and rate and keeps the pose
    push_tick(16'sh7FFF, 16'sh7FFF, 16'd0);
    push_tick(16'sh8000, 16'sh8000, 16'd0);
    push_tick(16'sh7FFF, 16'sd0, 16'hFFFF);
    push_tick(16'sh8000, 16'sd0, 16'hFFFF);
    push_tick(16'sd1, 16'sd1, 16'd1);
    push_tick(-16'sd1, -16'sd1, 16'd1);
    push_tick(16'sd0, 16'sh7FFF, 16'hFFFF);
    // right turns take the heading below zero
    push_tick(16'sd0, 16'sh8000, 16'hFFFF);
    push_tick(16'sd0, 16'sh8000, 16'hFFFF);
    push_tick(16'sh5555, 16'shAAAA, 16'hAAAA);
    push_tick(16'shAAAA, 16'sh5555, 16'h5555);
    push_tick(16'sh7FFF, 16'sh8000, 16'h0001);
    push_tick(16'sh8000, 16'sh7FFF, 16'hFFFF);
    // drive around all quadrants, wrapping the heading through zero
    repeat (11) push_tick(16'sd20000, 16'sh7FFF, 16'hFFFF);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
        1:       begin tx_idle_pct <= 76; rx_stall_pct <= 0;  end
        2:       begin tx_idle_pct <= 0;  rx_stall_pct <= 76; end
        default: begin tx_idle_pct <= 32; rx_stall_pct <= 32; end
      endcase
      for (int n = 0; n < PHASE_TICKS; n++) push_tick(rand_rate(), rand_rate(), rand_dt());
      if (ph == 0) hold_start <= 1'b1;
      wait_idle();
    end

    // turn in place toward the diagonal, then run flat out along it
    tx_idle_pct  <= 0;
    rx_stall_pct <= 0;
    for (int k = 0; k < 40; k++) begin
      err = $signed(DIAG_HEADING - est_heading);
      if (err > -STEER_TOL && err < STEER_TOL) break;
      // 2^32 over the turn scale is just under 6
      turn_units = clamp(err * 6 / 65535, -32768, 32767);
      if (turn_units == 0) turn_units = (err > 0) ? 1 : -1;
      push_tick(16'sd0, turn_units[15:0], 16'hFFFF);
      wait_idle();
    end

    // keep pressing along the diagonal, then wander
    tx_idle_pct  <= 32;
    rx_stall_pct <= 32;
    repeat (10) push_tick(16'sh7FFF, 16'sd0, 16'hFFFF);
    repeat (60) push_tick(rand_rate(), rand_rate(), rand_dt());
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fault_count == 0 && expected_poses.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
